// ===== design/crcfr_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the frame receiver.
`default_nettype none

package crcfr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES        = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_DATA    = 3'd1,
    OP_CRC     = 3'd2,
    OP_LAST    = 3'd3,
    OP_TIMEOUT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } q_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/crcfr_front.sv =====
// Front end: frame state machine and timeout, classifies each item into a queue op.
`default_nettype none

module crcfr_front import crcfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output q_entry_t         entry_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CRC     = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [1:0]  crc_cnt_q, crc_cnt_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] timeout_q;
  logic        accept;
  logic [16:0] tick_next;
  logic [7:0]  cnt_inc;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign tick_next  = {1'b0, elapsed_q} + 17'd1;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    crc_cnt_d = crc_cnt_q;
    elapsed_d = elapsed_q;
    push_o    = 1'b0;
    entry_o   = '{op: OP_DATA, data: rx_byte_i};
    if (accept) begin
      if (cmd_i) begin
        if (phase_q == PH_PAYLOAD || phase_q == PH_CRC) begin
          if (tick_next > {1'b0, timeout_q}) begin
            phase_d    = PH_IDLE;
            push_o     = 1'b1;
            entry_o.op = OP_TIMEOUT;
          end else begin
            elapsed_d = tick_next[15:0];
          end
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d      = rx_byte_i;
            cnt_d      = 8'd0;
            crc_cnt_d  = 2'd0;
            elapsed_d  = 16'd0;
            phase_d    = (rx_byte_i == 8'd0) ? PH_CRC : PH_PAYLOAD;
            push_o     = 1'b1;
            entry_o.op = OP_START;
          end
          PH_PAYLOAD: begin
            cnt_d  = cnt_inc;
            if (cnt_inc == len_q) begin
              phase_d = PH_CRC;
            end
            push_o     = 1'b1;
            entry_o.op = OP_DATA;
          end
          default: begin
            push_o = 1'b1;
            if (crc_cnt_q == 2'd3) begin
              crc_cnt_d  = 2'd0;
              phase_d    = PH_IDLE;
              entry_o.op = OP_LAST;
            end else begin
              crc_cnt_d  = crc_cnt_q + 2'd1;
              entry_o.op = OP_CRC;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      len_q     <= 8'd0;
      cnt_q     <= 8'd0;
      crc_cnt_q <= 2'd0;
      elapsed_q <= 16'd0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      crc_cnt_q <= crc_cnt_d;
      elapsed_q <= elapsed_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

`ifndef ASSERT_OFF
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.op == OP_TIMEOUT) |=> phase_q == PH_IDLE)
    else $error("timeout did not return the frame to idle");
`endif

endmodule

`default_nettype wire

// ===== design/crcfr_queue.sv =====
// Small FIFO of classified ops between the front end and the back end.
`default_nettype none

module crcfr_queue import crcfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          valid_o,
  output q_entry_t      entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// ===== design/crcfr_back.sv =====
// Back end: CRC accumulation, verdict compare and the output register.
`default_nettype none

module crcfr_back import crcfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire q_entry_t   entry_i,
  output logic            pop_o,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      frame_length_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] rcv_q, rcv_d;
  logic [7:0]  len_q, len_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  olen_q, olen_d;
  logic        produces, out_free;
  logic [31:0] rcv_shift;

  assign produces  = (entry_i.op != OP_START) && (entry_i.op != OP_CRC);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = q_valid_i && (!produces || out_free);
  assign rcv_shift = {rcv_q[23:0], entry_i.data};

  always_comb begin
    crc_d       = crc_q;
    rcv_d       = rcv_q;
    len_d       = len_q;
    kind_d      = kind_q;
    data_d      = data_q;
    olen_d      = olen_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    if (pop_o) begin
      unique case (entry_i.op)
        OP_START: begin
          len_d = entry_i.data;
          crc_d = CRC_ONES;
          rcv_d = 32'd0;
        end
        OP_DATA: begin
          crc_d       = crc_byte(crc_q, entry_i.data);
          out_valid_d = 1'b1;
          kind_d      = KIND_DATA;
          data_d      = entry_i.data;
          olen_d      = len_q;
        end
        OP_CRC: begin
          rcv_d = rcv_shift;
        end
        OP_LAST: begin
          rcv_d       = rcv_shift;
          out_valid_d = 1'b1;
          kind_d      = (rcv_shift == ~crc_q) ? KIND_OK : KIND_CRC_ERR;
          data_d      = 8'd0;
          olen_d      = len_q;
        end
        default: begin
          out_valid_d = 1'b1;
          kind_d      = KIND_TIMEOUT;
          data_d      = 8'd0;
          olen_d      = len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= CRC_ONES;
      rcv_q       <= 32'd0;
      len_q       <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
      rcv_q       <= rcv_d;
      len_q       <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    olen_q <= olen_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign frame_length_o = olen_q;

`ifndef ASSERT_OFF
  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_DATA) |-> data_q == 8'd0)
    else $error("verdict carries a data byte");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

// ===== design/crc32_frame_receiver.sv =====
// Usage: one input channel carries items that are either a received byte (cmd_i = 0,
// rx_byte_i) or one time tick (cmd_i = 1). A frame is a lead byte, a length byte, that
// many payload bytes and a big-endian CRC-32 over the payload. The output channel gives
// one item per payload byte (kind 0, the byte in data_byte_o) and one verdict per frame:
// frame ok, CRC error, or timeout when more ticks than timeout_ticks pass after the
// length byte. frame_length_o carries the current frame's length on every item.
// Both channels use valid/stall; an item moves on an edge with valid high, stall low.
// cfg_we_i writes timeout_ticks from cfg_wdata_i; reset value 1000.
// Throughput: one input item per cycle while in_stall_o is low; the back end updates
// the CRC a byte at a time and the front end runs the frame state machine.
// The front end and back end are joined by a QUEUE_DEPTH-entry FIFO. When the receiver
// stalls, the output register holds its item, the back end stops draining the FIFO and,
// once the FIFO is full, in_stall_o rises. Reset empties the FIFO, drops the output
// item and returns the frame state machine to waiting for a lead byte.
`default_nettype none

module crc32_frame_receiver import crcfr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       frame_length_o
);

  logic     push, q_full, q_valid, pop;
  q_entry_t push_entry, pop_entry;

  crcfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  crcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  crcfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .frame_length_o (frame_length_o)
  );

endmodule

`default_nettype wire

// ===== tb/crc32_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame receiver: watches both channels, predicts each result item and compares.
module crc32_frame_checker import crcfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  frame_length_i,
  output int               pending_o,
  output int               fail_count_o
);

  typedef enum logic [1:0] {
    WAIT_LEAD  = 2'd0,
    WAIT_LEN   = 2'd1,
    IN_PAYLOAD = 2'd2,
    IN_CRC     = 2'd3
  } rx_phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] len;
  } rx_result_t;

  rx_result_t  expected_q [$];
  rx_phase_e   phase;
  logic [7:0]  frame_len;
  logic [7:0]  bytes_seen;
  logic [31:0] crc_acc;
  logic [31:0] crc_rx;
  logic [1:0]  crc_idx;
  logic [15:0] ticks;
  logic [15:0] timeout;
  int          fails;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  // Reflected CRC-32, one input bit folded in per shift.
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  task automatic push_result(input kind_e k, input logic [7:0] d);
    rx_result_t r;
    r = '{kind: k, data: d, len: frame_len};
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic predict_item(input logic cmd, input logic [7:0] b);
    logic [16:0] next_ticks;
    if (cmd) begin
      if (phase == IN_PAYLOAD || phase == IN_CRC) begin
        next_ticks = {1'b0, ticks} + 17'd1;
        if (next_ticks > {1'b0, timeout}) begin
          phase = WAIT_LEAD;
          push_result(KIND_TIMEOUT, 8'd0);
        end else begin
          ticks = next_ticks[15:0];
        end
      end
    end else begin
      case (phase)
        WAIT_LEAD: begin
          phase = WAIT_LEN;
        end
        WAIT_LEN: begin
          frame_len  = b;
          bytes_seen = 8'd0;
          crc_acc    = CRC_ONES;
          crc_rx     = 32'd0;
          crc_idx    = 2'd0;
          ticks      = 16'd0;
          phase      = (b == 8'd0) ? IN_CRC : IN_PAYLOAD;
        end
        IN_PAYLOAD: begin
          crc_acc    = crc32_step(crc_acc, b);
          bytes_seen = bytes_seen + 8'd1;
          if (bytes_seen == frame_len) phase = IN_CRC;
          push_result(KIND_DATA, b);
        end
        default: begin
          crc_rx = {crc_rx[23:0], b};
          if (crc_idx == 2'd3) begin
            crc_idx = 2'd0;
            phase   = WAIT_LEAD;
            push_result((crc_rx == ~crc_acc) ? KIND_OK : KIND_CRC_ERR, 8'd0);
          end else begin
            crc_idx = crc_idx + 2'd1;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rx_result_t exp_r;
    if (!rst_ni) begin
      phase      = WAIT_LEAD;
      frame_len  = 8'd0;
      bytes_seen = 8'd0;
      crc_acc    = CRC_ONES;
      crc_rx     = 32'd0;
      crc_idx    = 2'd0;
      ticks      = 16'd0;
      timeout    = TIMEOUT_RESET;
      fails      = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) timeout = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_item(cmd_i, rx_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: kind %0d data_byte %0h frame_length %0d",
                 kind_i, data_byte_i, frame_length_i);
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          if (kind_i !== exp_r.kind) begin
            $error("kind: expected %0d, actual %0d", exp_r.kind, kind_i);
            fails++;
          end
          if (data_byte_i !== exp_r.data) begin
            $error("data_byte: expected %0h, actual %0h", exp_r.data, data_byte_i);
            fails++;
          end
          if (frame_length_i !== exp_r.len) begin
            $error("frame_length: expected %0d, actual %0d", exp_r.len, frame_length_i);
            fails++;
          end
        end
      end
    end
    pending_o    <= expected_q.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the frame receiver: clock, reset, frame stimulus, stalls and verdict.
module tb_top;
  import crcfr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int N_SETTINGS   = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        cmd_i       = 1'b0;
  logic [7:0]  rx_byte_i   = 8'd0;
  logic        out_stall_i = 1'b0;
  wire         in_stall_o;
  wire         out_valid_o;
  wire  [1:0]  kind_o;
  wire  [7:0]  data_byte_o;
  wire  [7:0]  frame_length_o;
  int          pending;
  int          fail_count;

  logic        quiet       = 1'b0;
  logic [15:0] cur_timeout = TIMEOUT_RESET;
  logic [7:0]  payload [256];
  int          sent_items  = 0;
  int          cycle_count = 0;

  crc32_frame_receiver i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .frame_length_o (frame_length_o)
  );

  crc32_frame_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .data_byte_i    (data_byte_o),
    .frame_length_i (frame_length_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always #6 clk_i = ~clk_i;

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // CRC over payload[0 .. len-1], final xor applied.
  function automatic logic [31:0] frame_crc(input int len);
    logic [31:0] c;
    c = CRC_ONES;
    for (int i = 0; i < len; i++) begin
      for (int k = 0; k < 8; k++) begin
        c = (c[0] ^ payload[i][k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  task automatic send_item(input logic c, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_timeout = v;
  endtask

  // cut_at < 0 sends the whole frame; otherwise the frame stops before byte cut_at
  // (counted after the length byte) and ticks run it into a timeout.
  task automatic send_frame(input logic [7:0] lead, input logic [7:0] len,
                            input logic [31:0] crc_flip, input int cut_at, input int tick_pct);
    logic [31:0] crc_word;
    int          ticks_since;
    int          n_bytes;
    logic [7:0]  b;
    crc_word    = frame_crc(int'(len)) ^ crc_flip;
    n_bytes     = len + 4;
    ticks_since = 0;
    send_item(1'b0, lead);
    if ($urandom_range(99) < tick_pct) send_tick();
    send_item(1'b0, len);
    for (int i = 0; i < n_bytes; i++) begin
      if (i == cut_at) break;
      while ($urandom_range(99) < tick_pct && ticks_since <= cur_timeout) begin
        send_tick();
        ticks_since++;
      end
      if (ticks_since > cur_timeout) return;
      b = (i < len) ? payload[i] : crc_word[8 * (3 - (i - len)) +: 8];
      send_item(1'b0, b);
    end
    if (cut_at >= 0 && cut_at < n_bytes) begin
      while (ticks_since <= cur_timeout) begin
        send_tick();
        ticks_since++;
      end
    end
  endtask

  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = quiet ? 0 : idle_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [15:0] settings [N_SETTINGS];
    logic [7:0]  len;
    logic [31:0] flip;
    int          cut;
    int          tick_pct;
    int          phase_start;
    bit          first;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // tick while idle, then an empty frame with a tick before its length byte
    send_tick();
    send_item(1'b0, 8'h00);
    send_tick();
    send_item(1'b0, 8'h00);
    repeat (4) send_item(1'b0, 8'h00);

    payload[0] = 8'h00;
    payload[1] = 8'hFF;
    payload[2] = 8'h5A;
    send_frame(8'hFF, 8'd3, 32'd0, -1, 30);

    payload[0] = 8'h80;
    send_frame(8'hA5, 8'd1, 32'h0000_0001, -1, 0);

    settings[0] = TIMEOUT_RESET;
    settings[1] = 16'd0;
    settings[2] = 16'd1;
    settings[3] = 16'hFFFF;
    settings[4] = 16'($urandom_range(2, 40));
    settings[5] = 16'($urandom_range(2, 40));
    settings[6] = 16'd3;
    settings[7] = 16'($urandom_range(2, 64));

    for (int p = 0; p < N_SETTINGS; p++) begin
      if (p > 0) write_timeout(settings[p]);
      quiet       = (p == 3);
      phase_start = sent_items;
      first       = 1'b1;
      while (sent_items - phase_start < RANDOM_ITEMS / N_SETTINGS) begin
        if (p == 3 && first) len = 8'd255;
        else if ($urandom_range(99) < 5) len = 8'($urandom_range(13, 64));
        else len = 8'($urandom_range(0, 12));
        for (int i = 0; i < len; i++) payload[i] = 8'($urandom_range(255));
        flip = 32'd0;
        if ($urandom_range(99) < 12) begin
          flip = $urandom;
          if (flip == 32'd0) flip = 32'd1;
        end
        cut = -1;
        if (cur_timeout <= 64 && (first || $urandom_range(99) < 8)) begin
          cut = $urandom_range(0, len + 3);
        end
        tick_pct = (cur_timeout < 2) ? 3 : $urandom_range(0, 15);
        if ($urandom_range(9) == 0) send_tick();
        send_frame(8'($urandom_range(255)), len, flip, cut, tick_pct);
        first = 1'b0;
      end
    end

    quiet = 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES * 2) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
